// ----- sv/cst_pkg.sv -----
// shared types and constants for the command stream tokenizer
// no dependencies; imported by the tokenizer, classify and state modules and the bench
`default_nettype none

package cst_pkg;

	localparam int MAX_NEST = 255;
	localparam int DEPTH_W  = $clog2(MAX_NEST + 1);

	localparam logic [7:0] CH_STMT_END   = 8'h3B;
	localparam logic [7:0] CH_CMD_SEP    = 8'h3A;
	localparam logic [7:0] CH_ARG_SEP    = 8'h2C;
	localparam logic [7:0] CH_ESC_OPEN   = 8'h7B;
	localparam logic [7:0] CH_ESC_CLOSE  = 8'h7D;
	localparam logic [7:0] CH_HIDDEN_SEP = 8'h06;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_DEL        = 8'h7F;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_CMD   = 3'd1,
		KIND_ARG   = 3'd2,
		KIND_BOUND = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CMD_SEP  = 2'd1,
		ERR_UNMATCH  = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               in_args;
	} tok_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic       had_args;
		err_t       error_code;
	} tok_result_t;

endpackage

`default_nettype wire

// ----- sv/cst_in_if.sv -----
// input channel of the tokenizer: one raw byte per item
// depends on nothing but the valid/ready handshake
`default_nettype none

interface cst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/cst_out_if.sv -----
// output channel of the tokenizer: one classified token per item
// field widths follow the result fields of the block
`default_nettype none

interface cst_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] char_value;
	logic       had_args;
	logic [1:0] error_code;

	modport source (output valid, output kind, output char_value, output had_args,
		output error_code, input ready);
	modport sink (input valid, input kind, input char_value, input had_args,
		input error_code, output ready);
endinterface

`default_nettype wire

// ----- sv/command_stream_tokenizer.sv -----
// command stream tokenizer: one byte in, one classified token out per item
// each byte is registered in stage 1 (byte_s1), its token then in the result register (res_s2)
// one item per cycle unless output stalls; the decision is one pass over the registered byte
// a stall on the output holds both stages; the input still takes an item while stage 1 is empty
// asynchronous reset clears valid flags, nesting depth and argument-part flag
// uses cst_pkg, cst_in_if, cst_out_if, cst_classify, cst_state
`default_nettype none

module command_stream_tokenizer (
	input wire logic clk,
	input wire logic arst_n,
	cst_in_if.sink   stream,
	cst_out_if.source tokens
);
	import cst_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	tok_result_t res_s2;
	logic        advance;
	tok_state_t  cur;
	tok_state_t  nxt;
	tok_result_t res;

	// stage 1 moves on whenever the result register is free or being emptied
	assign advance      = !valid_s2 || tokens.ready;
	assign stream.ready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (stream.ready)
				valid_s1 <= stream.valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid)
			byte_s1 <= stream.in_byte;
		if (advance && valid_s1)
			res_s2 <= res;
	end

	cst_classify u_classify (
		.in_byte (byte_s1),
		.cur     (cur),
		.nxt     (nxt),
		.res     (res)
	);

	cst_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance && valid_s1),
		.nxt    (nxt),
		.cur    (cur)
	);

	assign tokens.valid      = valid_s2;
	assign tokens.kind       = res_s2.kind;
	assign tokens.char_value = res_s2.char_value;
	assign tokens.had_args   = res_s2.had_args;
	assign tokens.error_code = res_s2.error_code;

endmodule

`default_nettype wire

// ----- sv/cst_classify.sv -----
// per-byte decision: token result and next nesting/part state
// uses cst_pkg for character codes, kinds, errors and state types
`default_nettype none

module cst_classify (
	input  wire logic [7:0]          in_byte,
	input  wire cst_pkg::tok_state_t cur,
	output cst_pkg::tok_state_t      nxt,
	output cst_pkg::tok_result_t     res
);
	import cst_pkg::*;

	logic               esc;
	logic               dropped;
	logic               at_max;
	logic [DEPTH_W-1:0] depth_dec;
	tok_result_t        char_res;
	logic [7:0]         char_in;

	assign esc       = (cur.depth != '0);
	assign at_max    = (cur.depth >= DEPTH_W'(MAX_NEST));
	assign depth_dec = cur.depth - DEPTH_W'(1);
	assign dropped   = (in_byte < CH_SPACE) || (in_byte == CH_DEL) || (in_byte == CH_SPACE);

	// kept character goes to whichever part is active
	always_comb begin
		char_in = (esc && in_byte == CH_ARG_SEP) ? CH_HIDDEN_SEP : in_byte;
		char_res = '{kind: KIND_CMD, char_value: char_in, had_args: 1'b0,
			error_code: ERR_NONE};
		if (cur.in_args) begin
			char_res.kind = KIND_ARG;
			if (char_in == CH_HIDDEN_SEP)
				char_res.char_value = CH_ARG_SEP;
		end
	end

	always_comb begin
		nxt = cur;
		res = '{kind: KIND_NONE, char_value: 8'h00, had_args: 1'b0, error_code: ERR_NONE};
		case (in_byte)
			CH_STMT_END: begin
				if (esc) begin
					res = char_res;
				end else begin
					res.kind     = KIND_END;
					res.had_args = cur.in_args;
					nxt.depth    = '0;
					nxt.in_args  = 1'b0;
				end
			end
			CH_CMD_SEP: begin
				if (esc)
					res = char_res;
				else if (cur.in_args)
					res.error_code = ERR_CMD_SEP;
				else
					nxt.in_args = 1'b1;
			end
			CH_ESC_OPEN: begin
				if (at_max) begin
					nxt.depth      = DEPTH_W'(MAX_NEST);
					res.error_code = ERR_OVERFLOW;
				end else begin
					if (esc)
						res = char_res;
					nxt.depth = cur.depth + DEPTH_W'(1);
				end
			end
			CH_ESC_CLOSE: begin
				if (!esc) begin
					res.error_code = ERR_UNMATCH;
				end else begin
					nxt.depth = depth_dec;
					if (depth_dec != '0)
						res = char_res;
				end
			end
			default: begin
				if (esc)
					res = char_res;
				else if (dropped)
					res.kind = KIND_NONE;
				else if (in_byte == CH_ARG_SEP && cur.in_args)
					res.kind = KIND_BOUND;
				else
					res = char_res;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/cst_state.sv -----
// nesting depth and argument-part flag of the tokenizer
// uses cst_pkg for the state type; cleared by reset and updated per item
`default_nettype none

module cst_state (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                update,
	input  wire cst_pkg::tok_state_t nxt,
	output cst_pkg::tok_state_t      cur
);
	import cst_pkg::*;

	tok_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (update) begin
			state_q <= nxt;
		end
	end

	assign cur = state_q;

endmodule

`default_nettype wire

// ----- bench/token_checker.sv -----
// token checker for the command stream tokenizer: predicts each token from the bytes fed
// in and compares it with the token stream; uses cst_pkg, cst_in_if and cst_out_if
`default_nettype none

module token_checker import cst_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	cst_in_if        byte_ch,
	cst_out_if       token_ch,
	output int       mismatches,
	output int       pending
);

	tok_result_t expected_tokens [$];
	int          nest_depth;
	logic        arg_part;
	int          token_idx;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 20) begin
			$display("token %0d: %s is 0x%0h, expected 0x%0h", token_idx, what, got, want);
		end
	endtask

	// a kept character goes to whichever part of the statement is open
	function automatic tok_result_t part_char(input logic [7:0] c);
		tok_result_t r;
		r = '0;
		if (arg_part) begin
			r.kind       = KIND_ARG;
			r.char_value = (c == CH_HIDDEN_SEP) ? CH_ARG_SEP : c;
		end else begin
			r.kind       = KIND_CMD;
			r.char_value = c;
		end
		return r;
	endfunction

	function automatic tok_result_t classify_byte(input logic [7:0] b);
		tok_result_t r;
		logic        escaped;
		r       = '0;
		r.kind  = KIND_NONE;
		escaped = (nest_depth != 0);
		case (b)
			CH_STMT_END: begin
				if (escaped) begin
					r = part_char(b);
				end else begin
					r.kind     = KIND_END;
					r.had_args = arg_part;
					nest_depth = 0;
					arg_part   = 1'b0;
				end
			end
			CH_CMD_SEP: begin
				if (escaped) begin
					r = part_char(b);
				end else if (arg_part) begin
					r.error_code = ERR_CMD_SEP;
				end else begin
					arg_part = 1'b1;
				end
			end
			CH_ESC_OPEN: begin
				if (nest_depth >= MAX_NEST) begin
					r.error_code = ERR_OVERFLOW;
				end else begin
					if (escaped) r = part_char(b);
					nest_depth++;
				end
			end
			CH_ESC_CLOSE: begin
				if (!escaped) begin
					r.error_code = ERR_UNMATCH;
				end else begin
					nest_depth--;
					// the brace closing the outer level is swallowed
					if (nest_depth != 0) r = part_char(b);
				end
			end
			default: begin
				if (escaped) begin
					r = part_char((b == CH_ARG_SEP) ? CH_HIDDEN_SEP : b);
				end else if (b < CH_SPACE || b == CH_SPACE || b == CH_DEL) begin
					r.kind = KIND_NONE;
				end else if (b == CH_ARG_SEP && arg_part) begin
					r.kind = KIND_BOUND;
				end else begin
					r = part_char(b);
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tok_result_t want;
		if (!arst_n) begin
			expected_tokens.delete();
			nest_depth = 0;
			arg_part   = 1'b0;
			mismatches = 0;
			token_idx  = 0;
			pending    = 0;
		end else begin
			if (token_ch.valid && token_ch.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token, kind", int'(token_ch.kind), 0);
				end else begin
					want = expected_tokens.pop_front();
					if (token_ch.kind !== want.kind)
						report_mismatch("kind", int'(token_ch.kind), int'(want.kind));
					if (token_ch.char_value !== want.char_value)
						report_mismatch("char_value", int'(token_ch.char_value),
							int'(want.char_value));
					if (token_ch.had_args !== want.had_args)
						report_mismatch("had_args", int'(token_ch.had_args),
							int'(want.had_args));
					if (token_ch.error_code !== want.error_code)
						report_mismatch("error_code", int'(token_ch.error_code),
							int'(want.error_code));
				end
				token_idx++;
			end
			if (byte_ch.valid && byte_ch.ready) begin
				expected_tokens = {expected_tokens, classify_byte(byte_ch.in_byte)};
			end
			pending = expected_tokens.size();
		end
	end

endmodule

`default_nettype wire

// ----- bench/command_stream_tokenizer_tb.sv -----
// testbench top for the command stream tokenizer: feeds directed and random statement
// streams with random gaps and output stalls; checking is done by token_checker
`default_nettype none

module command_stream_tokenizer_tb;
	import cst_pkg::*;

	localparam int RANDOM_BYTES = 560;

	logic clk = 1'b0;
	logic arst_n;

	cst_in_if  stream_ch();
	cst_out_if token_ch();

	int mismatches;
	int tokens_pending;
	int bytes_fed      = 0;
	int statements_fed = 0;
	int drains         = 0;
	int burst_left     = 0;
	int random_start;

	logic [15:0] rx_tick = '0;

	logic [7:0] directed_bytes [$] = '{
		8'h61, 8'hFF, 8'h00, CH_DEL, CH_SPACE, CH_ARG_SEP,
		CH_ESC_OPEN, CH_ARG_SEP, CH_HIDDEN_SEP, CH_ESC_OPEN, CH_STMT_END, CH_CMD_SEP,
		CH_ESC_CLOSE, CH_ESC_CLOSE, CH_ESC_CLOSE,
		CH_CMD_SEP, CH_CMD_SEP, CH_ARG_SEP, CH_HIDDEN_SEP,
		CH_ESC_OPEN, CH_ARG_SEP, CH_ESC_CLOSE, 8'h80, CH_STMT_END, CH_STMT_END
	};

	always #5 clk = ~clk;

	command_stream_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.tokens (token_ch)
	);

	token_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (stream_ch),
		.token_ch   (token_ch),
		.mismatches (mismatches),
		.pending    (tokens_pending)
	);

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver stall pattern, its character chosen by bits 10:8 of rx_tick
	always @(negedge clk) begin
		rx_tick <= rx_tick + 16'd1;
		case (rx_tick[10:8])
			3'd0, 3'd1: token_ch.ready <= 1'b1;
			3'd2:       token_ch.ready <= 1'($urandom_range(0, 1));
			3'd3:       token_ch.ready <= (rx_tick[1:0] == 2'd0);
			3'd4:       token_ch.ready <= ($urandom_range(0, 9) != 0);
			3'd5:       token_ch.ready <= (rx_tick[4:0] > 5'd13);
			default:    token_ch.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic feed_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				stream_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
		stream_ch.valid   <= 1'b1;
		stream_ch.in_byte <= b;
		do @(posedge clk); while (!stream_ch.ready);
		@(negedge clk);
		burst_left--;
		bytes_fed++;
	endtask

	task automatic drain_tokens();
		stream_ch.valid <= 1'b0;
		while (tokens_pending != 0) @(negedge clk);
		@(negedge clk);
		burst_left = 0;
		drains++;
	endtask

	function automatic logic [7:0] random_char();
		logic [7:0] c;
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		do c = 8'($urandom_range(8'h21, 8'h7E));
		while (c == CH_STMT_END || c == CH_CMD_SEP || c == CH_ARG_SEP
			|| c == CH_ESC_OPEN || c == CH_ESC_CLOSE);
		return c;
	endfunction

	// body of an escape, heavy on separators that must be kept
	task automatic feed_escaped_text();
		int n;
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1:    feed_byte(CH_ARG_SEP);
				2:       feed_byte(CH_STMT_END);
				3:       feed_byte(CH_CMD_SEP);
				4:       feed_byte(CH_HIDDEN_SEP);
				default: feed_byte(random_char());
			endcase
		end
	endtask

	task automatic feed_escape();
		int levels;
		levels = $urandom_range(1, 3);
		for (int l = 0; l < levels; l++) begin
			feed_byte(CH_ESC_OPEN);
			feed_escaped_text();
		end
		for (int l = 0; l < levels; l++) begin
			feed_byte(CH_ESC_CLOSE);
			if (l < levels - 1) feed_escaped_text();
		end
	endtask

	// text of a command or an argument, now and then with a stray separator
	task automatic feed_chars(input int n);
		repeat (n) begin
			case ($urandom_range(0, 29))
				0, 1, 2, 3, 4: feed_escape();
				5:             feed_byte(CH_ESC_CLOSE);
				6:             feed_byte(CH_CMD_SEP);
				default:       feed_byte(random_char());
			endcase
		end
	endtask

	task automatic feed_statement();
		int nargs;
		if ($urandom_range(0, 14) == 0) feed_byte(CH_ESC_CLOSE);
		feed_chars($urandom_range(0, 6));
		if ($urandom_range(0, 9) < 7) begin
			feed_byte(CH_CMD_SEP);
			nargs = $urandom_range(1, 4);
			for (int a = 0; a < nargs; a++) begin
				if (a > 0) feed_byte(CH_ARG_SEP);
				feed_chars($urandom_range(0, 5));
			end
		end
		if ($urandom_range(0, 19) != 0) feed_byte(CH_STMT_END);
		statements_fed++;
	endtask

	initial begin
		stream_ch.valid   = 1'b0;
		stream_ch.in_byte = 8'h00;
		token_ch.ready    = 1'b0;
		arst_n            = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_bytes[i]) feed_byte(directed_bytes[i]);
		drain_tokens();

		// fill the nesting to its limit, push past it, then unwind
		repeat (MAX_NEST) feed_byte(CH_ESC_OPEN);
		repeat (2) feed_byte(CH_ESC_OPEN);
		feed_byte(CH_CMD_SEP);
		repeat (MAX_NEST) feed_byte(CH_ESC_CLOSE);
		feed_byte(CH_STMT_END);
		drain_tokens();

		random_start = bytes_fed;
		while (bytes_fed - random_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) feed_byte(8'($urandom_range(0, 255)));
			end else begin
				feed_statement();
				if (statements_fed % 25 == 0) drain_tokens();
			end
		end

		stream_ch.valid <= 1'b0;
		while (tokens_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("fed %0d bytes: directed cases, nesting to the limit and past it, %0d statements",
			bytes_fed, statements_fed);
		$display("random gaps and output stalls, %0d full drains on the way", drains);
		if (mismatches == 0 && tokens_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
